### sv/clas_pkg.sv
`timescale 1ns / 1ps

package clas_pkg;

    localparam int MAX_BACKSLASH_RUN = 255;
    localparam logic [7:0] RUN_CAP = 8'(MAX_BACKSLASH_RUN > 255 ? 255 :
                                        (MAX_BACKSLASH_RUN < 1 ? 1 : MAX_BACKSLASH_RUN));

    localparam logic [2:0] PH_START        = 3'd0;
    localparam logic [2:0] PH_FIRST_QUOTED = 3'd1;
    localparam logic [2:0] PH_FIRST_PLAIN  = 3'd2;
    localparam logic [2:0] PH_GAP          = 3'd3;
    localparam logic [2:0] PH_ARG          = 3'd4;

    localparam logic [7:0] CHAR_NUL       = 8'h00;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;

    localparam logic [1:0]  QUOTE_LEVEL_WRAP = 2'd3;
    localparam logic [1:0]  QUOTE_LEVEL_HIGH = 2'd2;
    localparam logic [15:0] ARG_COUNT_MAX    = 16'hFFFF;

    typedef struct packed {
        logic [7:0]  backslash_run;
        logic        has_char;
        logic [7:0]  out_char;
        logic        arg_end;
        logic [15:0] arg_count;
        logic        empty_line;
        logic        run_overflow;
        logic        line_end;
    } result_t;

endpackage

### sv/command_line_argument_splitter.sv
`timescale 1ns / 1ps

// Streaming splitter that turns a command line into arguments by the Windows
// rules. Bytes enter on the input channel (in_valid, in_stall, in_byte), one
// beat per byte, and a zero byte ends the line. Each input beat yields exactly
// one output beat on (out_valid, out_stall) carrying the backslash count to
// emit, an optional character, and argument-end, line-end, empty-line and
// run-overflow marks, plus the running argument count.
// An input beat is captured in an input register, decoded against the
// running tokenizer state combinationally, and written to the result register
// once the result register can take it, so an output stall can delay a result.
// Throughput is one byte per cycle while out_stall is low; the state update is
// a single short combinational step between the input and result registers.
// When out_stall is high and a result is waiting, the result register holds
// and the input register holds its byte, so in_stall rises only when both
// registers are full. After rst_n is released the block is at line start with
// both registers empty. After each zero byte the state returns to line start.
module command_line_argument_splitter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  backslash_run,
    output logic        has_char,
    output logic [7:0]  out_char,
    output logic        arg_end,
    output logic [15:0] arg_count,
    output logic        empty_line,
    output logic        run_overflow,
    output logic        line_end
);

    logic             s1_valid_reg;
    logic [7:0]       s1_byte_reg;
    logic             out_valid_reg;
    clas_pkg::result_t result_reg;
    clas_pkg::result_t result_next;

    logic [2:0]  phase_reg, phase_next;
    logic [1:0]  quote_level_reg, quote_level_next;
    logic        in_quote_run_reg, in_quote_run_next;
    logic [7:0]  pending_reg, pending_next;
    logic [15:0] args_started_reg, args_started_next;

    logic advance_out;
    logic fire;
    logic accept;

    assign advance_out = !out_valid_reg || !out_stall;
    assign fire        = s1_valid_reg && advance_out;
    assign in_stall    = s1_valid_reg && !advance_out;
    assign accept      = in_valid && !in_stall;

    always_comb
    begin
        logic [7:0]  c;
        logic        blank;
        logic [1:0]  ql;
        logic        iqr;
        logic [7:0]  pb;
        logic [1:0]  ql_inc;
        logic [15:0] args_inc;
        logic        handle;

        c        = s1_byte_reg;
        blank    = c inside {clas_pkg::CHAR_SPACE, clas_pkg::CHAR_TAB};
        args_inc = (args_started_reg != clas_pkg::ARG_COUNT_MAX) ?
                   args_started_reg + 16'd1 : args_started_reg;
        handle   = 1'b0;
        ql       = quote_level_reg;
        iqr      = in_quote_run_reg;
        pb       = pending_reg;
        ql_inc   = 2'd0;

        phase_next        = phase_reg;
        quote_level_next  = quote_level_reg;
        in_quote_run_next = in_quote_run_reg;
        pending_next      = pending_reg;
        args_started_next = args_started_reg;

        result_next               = '0;

        if (c == clas_pkg::CHAR_NUL)
        begin
            result_next.line_end = 1'b1;
            case (phase_reg)
                clas_pkg::PH_FIRST_QUOTED, clas_pkg::PH_FIRST_PLAIN:
                begin
                    result_next.arg_end = 1'b1;
                end
                clas_pkg::PH_GAP:
                begin
                end
                clas_pkg::PH_ARG:
                begin
                    result_next.backslash_run = pending_reg;
                    result_next.arg_end       = 1'b1;
                end
                default:
                begin
                    result_next.empty_line = 1'b1;
                end
            endcase
        end
        else
        begin
            case (phase_reg)
                clas_pkg::PH_FIRST_QUOTED:
                begin
                    if (c == clas_pkg::CHAR_QUOTE)
                    begin
                        result_next.arg_end = 1'b1;
                        phase_next          = clas_pkg::PH_GAP;
                    end
                    else
                    begin
                        result_next.has_char = 1'b1;
                        result_next.out_char = c;
                    end
                end
                clas_pkg::PH_FIRST_PLAIN:
                begin
                    if (blank)
                    begin
                        result_next.arg_end = 1'b1;
                        phase_next          = clas_pkg::PH_GAP;
                    end
                    else
                    begin
                        result_next.has_char = 1'b1;
                        result_next.out_char = c;
                    end
                end
                clas_pkg::PH_GAP:
                begin
                    if (!blank)
                    begin
                        handle            = 1'b1;
                        args_started_next = args_inc;
                        phase_next        = clas_pkg::PH_ARG;
                        ql                = 2'd0;
                        iqr               = 1'b0;
                        pb                = 8'd0;
                    end
                end
                clas_pkg::PH_ARG:
                begin
                    handle = 1'b1;
                end
                default:
                begin
                    args_started_next = args_inc;
                    if (c == clas_pkg::CHAR_QUOTE)
                    begin
                        phase_next = clas_pkg::PH_FIRST_QUOTED;
                    end
                    else if (blank)
                    begin
                        result_next.arg_end = 1'b1;
                        phase_next          = clas_pkg::PH_GAP;
                    end
                    else
                    begin
                        result_next.has_char = 1'b1;
                        result_next.out_char = c;
                        phase_next           = clas_pkg::PH_FIRST_PLAIN;
                    end
                end
            endcase

            if (handle)
            begin
                if (iqr && c != clas_pkg::CHAR_QUOTE)
                begin
                    iqr = 1'b0;
                    if (ql == clas_pkg::QUOTE_LEVEL_HIGH)
                    begin
                        ql = 2'd0;
                    end
                end
                if (blank && ql == 2'd0)
                begin
                    result_next.backslash_run = pb;
                    result_next.arg_end       = 1'b1;
                    pb                        = 8'd0;
                    phase_next                = clas_pkg::PH_GAP;
                end
                else if (c == clas_pkg::CHAR_BACKSLASH)
                begin
                    if (pb >= clas_pkg::RUN_CAP)
                    begin
                        result_next.run_overflow = 1'b1;
                    end
                    else
                    begin
                        pb = pb + 8'd1;
                    end
                end
                else if (c == clas_pkg::CHAR_QUOTE)
                begin
                    if (iqr || !pb[0])
                    begin
                        ql_inc = ql + 2'd1;
                        if (ql_inc == clas_pkg::QUOTE_LEVEL_WRAP)
                        begin
                            result_next.has_char = 1'b1;
                            result_next.out_char = clas_pkg::CHAR_QUOTE;
                            ql                   = 2'd0;
                        end
                        else
                        begin
                            ql = ql_inc;
                        end
                    end
                    else
                    begin
                        result_next.has_char = 1'b1;
                        result_next.out_char = clas_pkg::CHAR_QUOTE;
                    end
                    if (!iqr)
                    begin
                        result_next.backslash_run = {1'b0, pb[7:1]};
                        pb                        = 8'd0;
                        iqr                       = 1'b1;
                    end
                end
                else
                begin
                    result_next.backslash_run = pb;
                    result_next.has_char      = 1'b1;
                    result_next.out_char      = c;
                    pb                        = 8'd0;
                end
                quote_level_next  = ql;
                in_quote_run_next = iqr;
                pending_next      = pb;
            end
        end

        result_next.arg_count = args_started_next;

        if (c == clas_pkg::CHAR_NUL)
        begin
            phase_next        = clas_pkg::PH_START;
            quote_level_next  = 2'd0;
            in_quote_run_next = 1'b0;
            pending_next      = 8'd0;
            args_started_next = 16'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            phase_reg        <= clas_pkg::PH_START;
            quote_level_reg  <= 2'd0;
            in_quote_run_reg <= 1'b0;
            pending_reg      <= 8'd0;
            args_started_reg <= 16'd0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance_out)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire)
            begin
                phase_reg        <= phase_next;
                quote_level_reg  <= quote_level_next;
                in_quote_run_reg <= in_quote_run_next;
                pending_reg      <= pending_next;
                args_started_reg <= args_started_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= in_byte;
        end
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign backslash_run = result_reg.backslash_run;
    assign has_char      = result_reg.has_char;
    assign out_char      = result_reg.out_char;
    assign arg_end       = result_reg.arg_end;
    assign arg_count     = result_reg.arg_count;
    assign empty_line    = result_reg.empty_line;
    assign run_overflow  = result_reg.run_overflow;
    assign line_end      = result_reg.line_end;

endmodule
